// ===== rtl/assert_macros.svh =====
// assert_macros.svh: concurrent assertion helpers for the glyph classifier rtl
// no dependencies; taken in by `include inside the modules that assert
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// same-cycle implication out of reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pgc_pkg.sv =====
// pgc_pkg: constants, codes, result type and helper functions for the glyph classifier
// no dependencies; imported by pixel_glyph_classifier
`default_nettype none

package pgc_pkg;

    // sizing
    localparam int MAX_WIDTH   = 1024;
    localparam int LEVEL_COUNT = 8;
    localparam int PIXEL_FULL  = 255;
    localparam int DIGIT_COUNT = 10;
    localparam int MAX_ROWS    = 1024;

    localparam int PIX_W   = 8;
    localparam int GLYPH_W = 4;
    localparam int OCOL_W  = 10;
    localparam int OROW_W  = 10;
    localparam int CFG_W   = 11;
    localparam int CIDX_W  = 2;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int EW_W    = $clog2(MAX_WIDTH + 1);
    localparam int GEO_W   = (EW_W > CFG_W) ? EW_W : CFG_W;
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int EH_W    = $clog2(MAX_ROWS + 1);

    // quantizer step sizes, a zero step taken as one
    localparam int LEVEL_DIV = (PIXEL_FULL / LEVEL_COUNT == 0) ? 1 : PIXEL_FULL / LEVEL_COUNT;
    localparam int DIGIT_DIV = (255 / DIGIT_COUNT == 0) ? 1 : 255 / DIGIT_COUNT;

    // register indexes
    localparam logic [CIDX_W-1:0] CFG_MODE      = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_WIDTH     = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_HEIGHT    = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_THRESHOLD = 2'd3;

    // mode codes; unused codes behave as plain level
    localparam logic [2:0] MODE_LEVEL    = 3'd0;
    localparam logic [2:0] MODE_INVERTED = 3'd1;
    localparam logic [2:0] MODE_VEDGE    = 3'd2;
    localparam logic [2:0] MODE_HEDGE    = 3'd3;
    localparam logic [2:0] MODE_GRADIENT = 3'd4;
    localparam logic [2:0] MODE_DIGIT    = 3'd5;

    // one result before the output register
    typedef struct packed {
        logic [GLYPH_W-1:0] glyph;
        logic [OCOL_W-1:0]  col;
        logic [OROW_W-1:0]  row;
        logic               frame_end;
    } t_result;

    function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // level index as a count of fixed thresholds passed, which caps by itself
    function automatic logic [GLYPH_W-1:0] level_glyph(input logic [PIX_W-1:0] pix,
                                                       input logic [2:0] mode);
        logic [4:0] q;
        q = 5'd0;
        if (mode == MODE_DIGIT) begin
            for (int k = 1; k < DIGIT_COUNT; k++) begin
                if (int'(pix) >= k * DIGIT_DIV) q = q + 5'd1;
            end
        end else begin
            for (int k = 1; k < LEVEL_COUNT; k++) begin
                if (int'(pix) >= k * LEVEL_DIV) q = q + 5'd1;
            end
            if (mode == MODE_INVERTED) q = 5'(LEVEL_COUNT - 1) - q;
        end
        return GLYPH_W'(q);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pixel_glyph_classifier.sv =====
// pixel_glyph_classifier: raster pixel to glyph code classifier, level and edge modes
// depends on pgc_pkg and assert_macros.svh
//
// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+------------------------------------------
// pixel     | in        | i_valid / o_stall  | i_pixel
// glyph     | out       | o_valid / i_stall  | o_glyph o_col o_row o_run_last o_frame_end
// config    | in        | i_cfg_we           | i_cfg_index i_cfg_data
//
// one pixel per cycle while o_stall is low; glyphs pass the stage and output registers;
// a pixel waits in the stage register until every glyph it yields is sent (up to three on
// the final row of an edge frame); the line buffer gives one row of delay in edge modes
// synchronous active-low reset; line buffer is not cleared
// a stalled output holds its glyph and the stage register behind it
`default_nettype none
`include "assert_macros.svh"

module pixel_glyph_classifier (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire [pgc_pkg::CIDX_W-1:0]    i_cfg_index,
    input  wire [pgc_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire [pgc_pkg::PIX_W-1:0]     i_pixel,
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic [pgc_pkg::GLYPH_W-1:0]  o_glyph,
    output logic [pgc_pkg::OCOL_W-1:0]   o_col,
    output logic [pgc_pkg::OROW_W-1:0]   o_row,
    output logic                         o_run_last,
    output logic                         o_frame_end
);
    import pgc_pkg::*;

    // configuration registers
    logic [2:0]       r_mode;
    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;
    logic [PIX_W-1:0] r_thr;

    // raster position and previous pixel
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [PIX_W-1:0] r_prev;

    // line buffer
    logic [PIX_W-1:0] r_line [MAX_WIDTH];

    // stage register
    logic             r_s1_valid;
    logic [2:0]       r_done;
    logic [PIX_W-1:0] r_s1_pix;
    logic [PIX_W-1:0] r_s1_prev;
    logic [COL_W-1:0] r_s1_col;
    logic [ROW_W-1:0] r_s1_row;
    logic             r_s1_last_row;
    logic             r_s1_last_col;
    logic [PIX_W-1:0] r_up;
    logic [PIX_W-1:0] r_up_right;

    // output register
    logic             r_out_valid;
    t_result          r_out;
    logic             r_out_last;

    logic [GEO_W-1:0] w_ext;
    logic [EW_W-1:0]  eff_w;
    logic [EH_W-1:0]  eff_h;
    logic             last_col;
    logic             last_row;
    logic             in_acc;
    logic             edge_mode;
    logic             edge_right;
    logic             edge_bot;
    logic             edge_prev;
    logic [2:0]       mask;
    logic [2:0]       pending;
    logic [2:0]       sel;
    logic             sel_last;
    logic             out_free;
    logic             adv;
    logic             s1_free;
    t_result          res [3];
    t_result          res_sel;

    // effective geometry
    always_comb begin
        w_ext = GEO_W'(r_width);
        if (w_ext == '0) begin
            eff_w = EW_W'(1);
        end else if (w_ext > GEO_W'(MAX_WIDTH)) begin
            eff_w = EW_W'(MAX_WIDTH);
        end else begin
            eff_w = EW_W'(w_ext);
        end
        if (r_height == '0) begin
            eff_h = EH_W'(1);
        end else if (r_height > CFG_W'(MAX_ROWS)) begin
            eff_h = EH_W'(MAX_ROWS);
        end else begin
            eff_h = EH_W'(r_height);
        end
    end

    assign last_col = (EW_W'(r_col) + EW_W'(1)) == eff_w;
    assign last_row = (EH_W'(r_row) + EH_W'(1)) == eff_h;

    // handshake
    assign pending  = mask & ~r_done;
    assign out_free = !r_out_valid || !i_stall;
    assign adv      = r_s1_valid && (pending != 3'b000) && out_free;
    assign s1_free  = !r_s1_valid || (pending == 3'b000) || (adv && sel_last);
    assign o_stall  = !s1_free;
    assign in_acc   = i_valid && s1_free;

    // configuration and raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_LEVEL;
            r_width  <= CFG_W'(64);
            r_height <= CFG_W'(64);
            r_thr    <= PIX_W'(32);
            r_col    <= '0;
            r_row    <= '0;
            r_prev   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MODE: begin
                    r_mode <= i_cfg_data[2:0];
                end
                CFG_WIDTH: begin
                    r_width <= i_cfg_data;
                    r_col   <= '0;
                    r_row   <= '0;
                end
                CFG_HEIGHT: begin
                    r_height <= i_cfg_data;
                    r_col    <= '0;
                    r_row    <= '0;
                end
                CFG_THRESHOLD: begin
                    r_thr <= i_cfg_data[PIX_W-1:0];
                end
                default: begin
                end
            endcase
        end else if (in_acc) begin
            r_prev <= i_pixel;
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // line buffer: write this pixel, read the row above and its right neighbour
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_line[r_col] <= i_pixel;
            r_up          <= r_line[r_col];
            r_up_right    <= r_line[r_col + COL_W'(1)];
        end
    end

    // stage register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_done     <= 3'b000;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
            r_done     <= 3'b000;
        end else if (s1_free) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_done <= r_done | sel;
        end
    end

    // stage register payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pix      <= i_pixel;
            r_s1_prev     <= r_prev;
            r_s1_col      <= r_col;
            r_s1_row      <= r_row;
            r_s1_last_row <= last_row;
            r_s1_last_col <= last_col;
        end
    end

    // edge tests and result candidates
    always_comb begin
        edge_mode  = (r_mode == MODE_VEDGE) || (r_mode == MODE_HEDGE) ||
                     (r_mode == MODE_GRADIENT);
        edge_right = !r_s1_last_col && (abs_diff(r_up, r_up_right) >= r_thr);
        edge_bot   = abs_diff(r_up, r_s1_pix) >= r_thr;
        edge_prev  = abs_diff(r_s1_prev, r_s1_pix) >= r_thr;

        if (edge_mode) begin
            mask = {r_s1_last_row && r_s1_last_col,
                    r_s1_last_row && (r_s1_col != '0),
                    r_s1_row != '0};
            res[0].glyph     = {2'b00, (r_mode != MODE_VEDGE) && edge_bot,
                                (r_mode != MODE_HEDGE) && edge_right};
            res[0].row       = OROW_W'(r_s1_row - ROW_W'(1));
            res[0].frame_end = 1'b0;
        end else begin
            mask             = 3'b001;
            res[0].glyph     = level_glyph(r_s1_pix, r_mode);
            res[0].row       = OROW_W'(r_s1_row);
            res[0].frame_end = r_s1_last_row && r_s1_last_col;
        end
        res[0].col = OCOL_W'(r_s1_col);

        // left neighbour on the final row
        res[1].glyph     = {3'b000, (r_mode != MODE_HEDGE) && edge_prev};
        res[1].col       = OCOL_W'(r_s1_col - COL_W'(1));
        res[1].row       = OROW_W'(r_s1_row);
        res[1].frame_end = 1'b0;

        // final pixel of an edge frame is always space
        res[2].glyph     = '0;
        res[2].col       = OCOL_W'(r_s1_col);
        res[2].row       = OROW_W'(r_s1_row);
        res[2].frame_end = 1'b1;
    end

    // lowest pending result goes next
    always_comb begin
        priority if (pending[0]) begin
            sel     = 3'b001;
            res_sel = res[0];
        end else if (pending[1]) begin
            sel     = 3'b010;
            res_sel = res[1];
        end else begin
            sel     = 3'b100;
            res_sel = res[2];
        end
        sel_last = (pending & ~sel) == 3'b000;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out      <= res_sel;
            r_out_last <= sel_last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_glyph     = r_out.glyph;
    assign o_col       = r_out.col;
    assign o_row       = r_out.row;
    assign o_frame_end = r_out.frame_end;
    assign o_run_last  = r_out_last;

    // checks
    `ASSERT_ALWAYS(a_col_in_row, i_clk, i_rst_n, EW_W'(r_col) < eff_w, "column past row end")
    `ASSERT_ALWAYS(a_row_in_frame, i_clk, i_rst_n, EH_W'(r_row) < eff_h, "row past frame end")
    `ASSERT_IMPLY(a_done_subset, i_clk, i_rst_n, r_s1_valid, (r_done & ~mask) == 3'b000, "result sent that was never due")
    `ASSERT_IMPLY(a_frame_end_last, i_clk, i_rst_n, o_valid && o_frame_end, o_run_last, "frame end not on last result")

endmodule

`default_nettype wire
